[rtl/core/a9pr_pkg.sv]
// Shared types and constants for the 9-bit addressed packet receiver.
package a9pr_pkg;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_CHAR = 2'd0,
      OP_ARM  = 2'd1,
      OP_STOP = 2'd2
   } op_type;

   // Response status codes
   typedef enum logic [3:0] {
      ST_IGNORED  = 4'd0,
      ST_ADDRESS  = 4'd1,
      ST_DATA     = 4'd2,
      ST_COMPLETE = 4'd3,
      ST_OVERFLOW = 4'd4,
      ST_LINE_ERR = 4'd5,
      ST_ARMED    = 4'd6,
      ST_REFUSED  = 4'd7,
      ST_STOPPED  = 4'd8
   } status_type;

   localparam logic [7:0] SUM_XOR  = 8'hAA;
   localparam logic [7:0] ACK_BYTE = 8'hFF;

   // One response as it sits in the output or skid register
   typedef struct packed {
      status_type status;
      logic [7:0] data_byte;
      logic [5:0] byte_index;
      logic       receiving;
      logic       packet_done;
      logic       checksum_ok;
      logic       ack_ok;
      logic       line_error_flag;
      logic       overflow_flag;
      logic       rx_enabled;
   } rsp_type;

endpackage

[rtl/core/addressed_9bit_packet_receiver_core.sv]
// Top level of the 9-bit multidrop packet receiver with address filtering.

// Receive side of a 9-bit multidrop serial link. Each request carries either a
// received character (data bits, ninth bit, framing and overrun flags), an arm
// command with the expected packet length, or a stop command, and produces
// exactly one response. While address detection is on, only an address
// character equal to the node address opens a packet; data characters are then
// numbered from 1, checked against the armed length and BUF_DEPTH, and passed
// out with their index. A running checksum of (byte + index) xor 0xAA covers
// all bytes but the last, which is compared against it; the byte at index 1 is
// checked against 0xFF as the acknowledge. Line errors and overflow abort the
// packet and set sticky flags that only reset clears. Rate: one request per
// clock cycle while req_stall is low; a request is decoded in the cycle it is
// accepted and its response is registered. An output register backed by a
// one-entry skid register decouples the two sides; req_stall rises only while
// the skid register holds a response that the consumer has not taken.
module addressed_9bit_packet_receiver_core #(
   parameter int BUF_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [7:0]            req_rx_byte,
   input  logic                  req_ninth_bit,
   input  logic                  req_framing_error,
   input  logic                  req_overrun_error,
   input  logic [7:0]            req_packet_length,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output a9pr_pkg::status_type  rsp_status,
   output logic [7:0]            rsp_data_byte,
   output logic [5:0]            rsp_byte_index,
   output logic                  rsp_receiving,
   output logic                  rsp_packet_done,
   output logic                  rsp_checksum_ok,
   output logic                  rsp_ack_ok,
   output logic                  rsp_line_error_flag,
   output logic                  rsp_overflow_flag,
   output logic                  rsp_rx_enabled
);
   import a9pr_pkg::*;

   // The index counter must hold BUF_DEPTH itself
   localparam int IDX_W = $clog2(BUF_DEPTH + 1);

   // Receiver state
   logic             node_address_ff;
   logic [7:0]       node_addr_ff;
   logic             enabled_ff,         enabled_in;
   logic             address_mode_ff,    address_mode_in;
   logic             in_packet_ff,       in_packet_in;
   logic             done_flag_ff,       done_flag_in;
   logic [IDX_W-1:0] next_index_ff,      next_index_in;
   logic [7:0]       expected_length_ff, expected_length_in;
   logic [7:0]       running_sum_ff,     running_sum_in;
   logic             sum_match_ff,       sum_match_in;
   logic             ack_match_ff,       ack_match_in;
   logic             line_err_ff,        line_err_in;
   logic             buf_err_ff,         buf_err_in;

   // Output register and skid register
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic             skid_valid_ff;
   rsp_type          skid_ff;

   rsp_type          res_in;
   status_type       status_in;
   logic [7:0]       dbyte_in;
   logic [IDX_W-1:0] idx_in;

   logic             req_fire;
   logic             rsp_fire;
   logic [7:0]       cur_idx8;
   logic [7:0]       data_term;
   logic [8:0]       next_count;

   // Stall requests only while the skid register is occupied
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid & ~skid_valid_ff;
   assign rsp_fire  = rsp_valid_ff & ~rsp_stall;

   // Checksum term for the current data character
   assign cur_idx8   = 8'(next_index_ff);
   assign data_term  = (req_rx_byte + cur_idx8) ^ SUM_XOR;
   // Count of bytes received once this one is taken
   assign next_count = 9'(next_index_ff) + 9'd1;

   // Node address register; the user must write it only while the block is idle (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         node_addr_ff    <= 8'd0;
         node_address_ff <= 1'b0;
      end else if (csr_wr_en) begin
         node_addr_ff    <= csr_wr_data;
         node_address_ff <= 1'b1;
      end
   end

   // Decode one request against the current state
   always_comb begin
      enabled_in         = enabled_ff;
      address_mode_in    = address_mode_ff;
      in_packet_in       = in_packet_ff;
      done_flag_in       = done_flag_ff;
      next_index_in      = next_index_ff;
      expected_length_in = expected_length_ff;
      running_sum_in     = running_sum_ff;
      sum_match_in       = sum_match_ff;
      ack_match_in       = ack_match_ff;
      line_err_in        = line_err_ff;
      buf_err_in         = buf_err_ff;
      status_in          = ST_IGNORED;
      dbyte_in           = 8'd0;
      idx_in             = '0;

      case (req_op)
         OP_CHAR: begin
            if (!enabled_ff) begin
               status_in = ST_IGNORED;
            end else if (req_framing_error || req_overrun_error) begin
               // Abort on any line error, whatever the mode
               enabled_in      = 1'b0;
               address_mode_in = 1'b1;
               in_packet_in    = 1'b0;
               done_flag_in    = 1'b0;
               line_err_in     = 1'b1;
               status_in       = ST_LINE_ERR;
            end else if (address_mode_ff) begin
               if (req_ninth_bit && (req_rx_byte == node_addr_ff)) begin
                  address_mode_in = 1'b0;
                  in_packet_in    = 1'b1;
                  next_index_in   = IDX_W'(1);
                  running_sum_in  = req_rx_byte ^ SUM_XOR;
                  sum_match_in    = 1'b0;
                  ack_match_in    = 1'b0;
                  dbyte_in        = req_rx_byte;
                  status_in       = ST_ADDRESS;
               end
            end else if (next_index_ff < IDX_W'(BUF_DEPTH)) begin
               next_index_in = IDX_W'(next_count);
               if (next_index_ff == IDX_W'(1)) begin
                  ack_match_in = (req_rx_byte == ACK_BYTE);
               end
               dbyte_in = req_rx_byte;
               idx_in   = next_index_ff;
               if (next_count >= 9'(expected_length_ff)) begin
                  sum_match_in    = (req_rx_byte == running_sum_ff);
                  enabled_in      = 1'b0;
                  address_mode_in = 1'b1;
                  in_packet_in    = 1'b0;
                  done_flag_in    = 1'b1;
                  status_in       = ST_COMPLETE;
               end else begin
                  running_sum_in = running_sum_ff + data_term;
                  status_in      = ST_DATA;
               end
            end else begin
               // Buffer full: abort and flag overflow
               enabled_in      = 1'b0;
               address_mode_in = 1'b1;
               in_packet_in    = 1'b0;
               done_flag_in    = 1'b0;
               buf_err_in      = 1'b1;
               status_in       = ST_OVERFLOW;
            end
         end
         OP_ARM: begin
            if (enabled_ff) begin
               status_in = ST_REFUSED;
            end else begin
               expected_length_in = req_packet_length;
               done_flag_in       = 1'b0;
               address_mode_in    = 1'b1;
               enabled_in         = 1'b1;
               status_in          = ST_ARMED;
            end
         end
         OP_STOP: begin
            enabled_in   = 1'b0;
            done_flag_in = 1'b0;
            in_packet_in = 1'b0;
            status_in    = ST_STOPPED;
         end
         default: begin
            status_in = ST_IGNORED;
         end
      endcase
   end

   // Assemble the response; flags show the state after this request
   always_comb begin
      res_in.status          = status_in;
      res_in.data_byte       = dbyte_in;
      res_in.byte_index      = 6'(idx_in);
      res_in.receiving       = in_packet_in;
      res_in.packet_done     = done_flag_in;
      res_in.checksum_ok     = sum_match_in;
      res_in.ack_ok          = ack_match_in;
      res_in.line_error_flag = line_err_in;
      res_in.overflow_flag   = buf_err_in;
      res_in.rx_enabled      = enabled_in;
   end

   // Advance receiver state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff         <= 1'b0;
         address_mode_ff    <= 1'b1;
         in_packet_ff       <= 1'b0;
         done_flag_ff       <= 1'b0;
         next_index_ff      <= '0;
         expected_length_ff <= 8'd0;
         running_sum_ff     <= 8'd0;
         sum_match_ff       <= 1'b0;
         ack_match_ff       <= 1'b0;
         line_err_ff        <= 1'b0;
         buf_err_ff         <= 1'b0;
      end else if (req_fire) begin
         enabled_ff         <= enabled_in;
         address_mode_ff    <= address_mode_in;
         in_packet_ff       <= in_packet_in;
         done_flag_ff       <= done_flag_in;
         next_index_ff      <= next_index_in;
         expected_length_ff <= expected_length_in;
         running_sum_ff     <= running_sum_in;
         sum_match_ff       <= sum_match_in;
         ack_match_ff       <= ack_match_in;
         line_err_ff        <= line_err_in;
         buf_err_ff         <= buf_err_in;
      end
   end

   // Output and skid valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // Drain the skid register into the output register
         if (rsp_fire) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire) begin
         if (rsp_valid_ff && rsp_stall) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload: hold while stalled, park in skid when the output is busy
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            rsp_ff <= skid_ff;
         end
      end else if (req_fire) begin
         if (rsp_valid_ff && rsp_stall) begin
            skid_ff <= res_in;
         end else begin
            rsp_ff <= res_in;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_data_byte       = rsp_ff.data_byte;
   assign rsp_byte_index      = rsp_ff.byte_index;
   assign rsp_receiving       = rsp_ff.receiving;
   assign rsp_packet_done     = rsp_ff.packet_done;
   assign rsp_checksum_ok     = rsp_ff.checksum_ok;
   assign rsp_ack_ok          = rsp_ff.ack_ok;
   assign rsp_line_error_flag = rsp_ff.line_error_flag;
   assign rsp_overflow_flag   = rsp_ff.overflow_flag;
   assign rsp_rx_enabled      = rsp_ff.rx_enabled;

   // A parked response always sits behind a valid output
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a response with the output empty");

   // A packet is only open while the receiver is armed
   a_packet_needs_enable: assert property (@(posedge clock) disable iff (reset)
      in_packet_ff |-> enabled_ff)
      else $error("packet open with receiver disabled");

   // Sticky error flags never clear outside reset
   a_line_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (line_err_ff || buf_err_ff) |=> (line_err_ff || buf_err_ff))
      else $error("sticky error flag cleared");

   // The index never runs past the buffer depth
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      next_index_ff <= IDX_W'(BUF_DEPTH))
      else $error("packet index beyond buffer depth");

   // Node address is held after a write until the next write
   a_csr_hold: assert property (@(posedge clock) disable iff (reset)
      (node_address_ff && !csr_wr_en) |=> $stable(node_addr_ff))
      else $error("node address changed without a write");

endmodule

[tb/sv/addressed_9bit_packet_receiver_core_test.sv]
// Self-checking testbench for the 9-bit addressed packet receiver core.
`timescale 1ns / 100ps

module addressed_9bit_packet_receiver_core_test;
   import a9pr_pkg::*;

   localparam int         BUF_DEPTH   = 32;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         MAX_REPORTS = 40;

   // One request as the driver sees it: every field of the request channel.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic       ninth_bit;
      logic       framing_error;
      logic       overrun_error;
      logic [7:0] packet_length;
   } serial_req_type;

   // Clock, reset and DUT ports; every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_CHAR;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        req_ninth_bit = 1'b0;
   logic        req_framing_error = 1'b0;
   logic        req_overrun_error = 1'b0;
   logic [7:0]  req_packet_length = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   status_type  rsp_status;
   logic [7:0]  rsp_data_byte;
   logic [5:0]  rsp_byte_index;
   logic        rsp_receiving;
   logic        rsp_packet_done;
   logic        rsp_checksum_ok;
   logic        rsp_ack_ok;
   logic        rsp_line_error_flag;
   logic        rsp_overflow_flag;
   logic        rsp_rx_enabled;

   // Requests waiting for the driver, and responses the receiver owes us.
   serial_req_type pending_reqs[$];
   rsp_type        predicted_rsps[$];
   serial_req_type req_now;

   // Receiver state as predicted by the testbench.
   logic [7:0]  node_addr = 8'd0;
   bit          rx_armed = 1'b0;
   bit          hunting_address = 1'b1;
   bit          pkt_open = 1'b0;
   bit          pkt_finished = 1'b0;
   int unsigned next_pos = 0;
   logic [7:0]  armed_length = 8'd0;
   logic [7:0]  sum_acc = 8'd0;
   bit          sum_good = 1'b0;
   bit          ack_seen = 1'b0;
   bit          line_fault = 1'b0;
   bit          ovf_fault = 1'b0;

   // Idle control and bookkeeping.
   int unsigned req_gap_left = 0;
   int unsigned req_quiet_left = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_quiet_left = 0;
   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned addr_settings = 0;
   int unsigned n_complete = 0;
   int unsigned n_sum_good = 0;
   int unsigned n_overflow = 0;
   int unsigned n_line_err = 0;

   addressed_9bit_packet_receiver_core #(
      .BUF_DEPTH(BUF_DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_rx_byte         (req_rx_byte),
      .req_ninth_bit       (req_ninth_bit),
      .req_framing_error   (req_framing_error),
      .req_overrun_error   (req_overrun_error),
      .req_packet_length   (req_packet_length),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_byte_index      (rsp_byte_index),
      .rsp_receiving       (rsp_receiving),
      .rsp_packet_done     (rsp_packet_done),
      .rsp_checksum_ok     (rsp_checksum_ok),
      .rsp_ack_ok          (rsp_ack_ok),
      .rsp_line_error_flag (rsp_line_error_flag),
      .rsp_overflow_flag   (rsp_overflow_flag),
      .rsp_rx_enabled      (rsp_rx_enabled)
   );

   // 8 ns clock.
   initial begin
      forever #4 clock = ~clock;
   end

   // Print one line per mismatch (bounded) and count every one.
   task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch on response %0d: %s got %0d, want %0d",
                  checked_count, what, got, want);
      mismatch_count++;
   endtask

   // Draw the idle cycles ahead of the next request or response. Now and then
   // hold a stretch of back-to-back traffic so full-rate behavior gets hit too.
   function automatic int unsigned draw_wait(ref int unsigned quiet_left);
      if (quiet_left != 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // Abort the packet in progress: disable, go back to address hunting.
   function automatic void drop_packet();
      rx_armed        = 1'b0;
      hunting_address = 1'b1;
      pkt_open        = 1'b0;
      pkt_finished    = 1'b0;
   endfunction

   // Advance the predicted receiver by one request and queue its response.
   function automatic void compute_rx_response(serial_req_type r);
      rsp_type     e;
      int unsigned pos;
      logic [7:0]  pos8;
      e        = '0;
      e.status = ST_IGNORED;
      case (r.op)
         OP_CHAR: begin
            if (!rx_armed) begin
               e.status = ST_IGNORED;
            end else if (r.framing_error || r.overrun_error) begin
               // line errors abort in any mode and latch the sticky flag
               drop_packet();
               line_fault = 1'b1;
               e.status   = ST_LINE_ERR;
               n_line_err++;
            end else if (hunting_address) begin
               // only our own address character opens a packet
               if (r.ninth_bit && r.rx_byte == node_addr) begin
                  hunting_address = 1'b0;
                  pkt_open        = 1'b1;
                  next_pos        = 1;
                  sum_acc         = r.rx_byte ^ SUM_XOR;
                  sum_good        = 1'b0;
                  ack_seen        = 1'b0;
                  e.status        = ST_ADDRESS;
                  e.data_byte     = r.rx_byte;
                  e.byte_index    = 6'd0;
               end
            end else if (next_pos < BUF_DEPTH) begin
               // inside a packet the ninth bit is ignored: everything is data
               pos      = next_pos;
               pos8     = 8'(pos);
               next_pos = pos + 1;
               if (pos == 1)
                  ack_seen = (r.rx_byte == ACK_BYTE);
               e.data_byte  = r.rx_byte;
               e.byte_index = 6'(pos);
               if (next_pos >= armed_length) begin
                  sum_good        = (r.rx_byte == sum_acc);
                  rx_armed        = 1'b0;
                  hunting_address = 1'b1;
                  pkt_open        = 1'b0;
                  pkt_finished    = 1'b1;
                  e.status        = ST_COMPLETE;
                  n_complete++;
                  if (sum_good)
                     n_sum_good++;
               end else begin
                  sum_acc  = sum_acc + ((r.rx_byte + pos8) ^ SUM_XOR);
                  e.status = ST_DATA;
               end
            end else begin
               drop_packet();
               ovf_fault = 1'b1;
               e.status  = ST_OVERFLOW;
               n_overflow++;
            end
         end
         OP_ARM: begin
            if (rx_armed) begin
               e.status = ST_REFUSED;
            end else begin
               armed_length    = r.packet_length;
               pkt_finished    = 1'b0;
               hunting_address = 1'b1;
               rx_armed        = 1'b1;
               e.status        = ST_ARMED;
            end
         end
         OP_STOP: begin
            // stop leaves address hunting as it is
            rx_armed     = 1'b0;
            pkt_finished = 1'b0;
            pkt_open     = 1'b0;
            e.status     = ST_STOPPED;
         end
         default: e.status = ST_IGNORED;
      endcase
      e.receiving       = pkt_open;
      e.packet_done     = pkt_finished;
      e.checksum_ok     = sum_good;
      e.ack_ok          = ack_seen;
      e.line_error_flag = line_fault;
      e.overflow_flag   = ovf_fault;
      e.rx_enabled      = rx_armed;
      predicted_rsps.push_back(e);
   endfunction

   // Request driver: predict on acceptance, then hold, idle or advance.
   always @(posedge clock) begin : req_driver
      serial_req_type nxt;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            compute_rx_response(req_now);
            accepted_count++;
         end
         // a stalled request stays put; otherwise the slot is free
         if (!req_valid || !req_stall) begin
            if (req_gap_left != 0) begin
               req_valid    <= 1'b0;
               req_gap_left <= req_gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               req_now           <= nxt;
               req_valid         <= 1'b1;
               req_op            <= nxt.op;
               req_rx_byte       <= nxt.rx_byte;
               req_ninth_bit     <= nxt.ninth_bit;
               req_framing_error <= nxt.framing_error;
               req_overrun_error <= nxt.overrun_error;
               req_packet_length <= nxt.packet_length;
               req_gap_left      <= draw_wait(req_quiet_left);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted response against the oldest
   // prediction, then draw how long to stall before taking the next one.
   always @(posedge clock) begin : rsp_monitor
      rsp_type     want;
      int unsigned hold;
      if (!reset) begin
         hold = rsp_hold_left;
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsps.size() == 0) begin
               flag_mismatch("response with none expected, status", rsp_status, 0);
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch("status", rsp_status, want.status);
               if (rsp_data_byte !== want.data_byte)
                  flag_mismatch("data_byte", rsp_data_byte, want.data_byte);
               if (rsp_byte_index !== want.byte_index)
                  flag_mismatch("byte_index", rsp_byte_index, want.byte_index);
               if (rsp_receiving !== want.receiving)
                  flag_mismatch("receiving", rsp_receiving, want.receiving);
               if (rsp_packet_done !== want.packet_done)
                  flag_mismatch("packet_done", rsp_packet_done, want.packet_done);
               if (rsp_checksum_ok !== want.checksum_ok)
                  flag_mismatch("checksum_ok", rsp_checksum_ok, want.checksum_ok);
               if (rsp_ack_ok !== want.ack_ok)
                  flag_mismatch("ack_ok", rsp_ack_ok, want.ack_ok);
               if (rsp_line_error_flag !== want.line_error_flag)
                  flag_mismatch("line_error_flag", rsp_line_error_flag,
                                want.line_error_flag);
               if (rsp_overflow_flag !== want.overflow_flag)
                  flag_mismatch("overflow_flag", rsp_overflow_flag, want.overflow_flag);
               if (rsp_rx_enabled !== want.rx_enabled)
                  flag_mismatch("rx_enabled", rsp_rx_enabled, want.rx_enabled);
            end
            checked_count++;
            hold = draw_wait(rsp_quiet_left);
         end else if (hold != 0) begin
            hold--;
         end
         rsp_stall     <= (hold != 0);
         rsp_hold_left <= hold;
      end
   end

   // Append one request to the driver's queue.
   function automatic void queue_req(logic [1:0] op, logic [7:0] b, bit ninth, bit fe,
                                     bit oe, logic [7:0] len);
      serial_req_type r;
      r.op            = op;
      r.rx_byte       = b;
      r.ninth_bit     = ninth;
      r.framing_error = fe;
      r.overrun_error = oe;
      r.packet_length = len;
      pending_reqs.push_back(r);
      queued_count++;
   endfunction

   // Queue an address character and max_data data characters. With
   // good_sum the completing character carries the correct checksum; with ack
   // the first data character is the acknowledge byte.
   task automatic queue_packet(logic [7:0] adr, int len, int max_data, bit good_sum,
                               bit ack);
      int         last_idx;
      int         idx;
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] pos8;
      last_idx = (len <= 1) ? 1 : len - 1;
      queue_req(OP_CHAR, adr, 1'b1, 1'b0, 1'b0, 8'($urandom_range(0, 255)));
      sum = adr ^ SUM_XOR;
      for (idx = 1; idx <= max_data; idx++) begin
         pos8 = 8'(idx);
         b    = 8'($urandom_range(0, 255));
         if (idx == 1 && ack)
            b = ACK_BYTE;
         if (idx == last_idx && good_sum)
            b = sum;
         queue_req(OP_CHAR, b, 1'($urandom_range(0, 1)), 1'b0, 1'b0,
                   8'($urandom_range(0, 255)));
         sum = sum + ((b + pos8) ^ SUM_XOR);
      end
   endtask

   // Queue one random chunk of traffic: mostly whole packets, some cut short,
   // the rest single random requests.
   task automatic queue_traffic(logic [7:0] adr);
      int pick;
      int len;
      int last_idx;
      int ndata;
      int sel;
      bit fe;
      pick = $urandom_range(0, 99);
      if (pick >= 80) begin
         fe = ($urandom_range(0, 3) == 0);
         queue_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), fe, ($urandom_range(0, 3) == 0),
                   8'($urandom_range(0, 255)));
      end else begin
         // mostly short packets; a few long enough to run past the buffer
         sel = $urandom_range(0, 19);
         if (sel < 2)
            len = $urandom_range(0, 1);
         else if (sel < 16)
            len = $urandom_range(2, 12);
         else if (sel < 18)
            len = $urandom_range(13, 33);
         else
            len = $urandom_range(34, 255);
         last_idx = (len <= 1) ? 1 : len - 1;
         ndata    = (last_idx > BUF_DEPTH) ? BUF_DEPTH : last_idx;
         if ($urandom_range(0, 1))
            queue_req(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
         queue_req(OP_ARM, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'(len));
         // sometimes put a foreign character on the line first
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1))
               queue_req(OP_CHAR, adr, 1'b0, 1'b0, 1'b0, 8'($urandom_range(0, 255)));
            else
               queue_req(OP_CHAR, adr ^ 8'($urandom_range(1, 255)), 1'b1, 1'b0, 1'b0,
                         8'($urandom_range(0, 255)));
         end
         if (pick < 60) begin
            queue_packet(adr, len, ndata, ($urandom_range(0, 9) < 7),
                         1'($urandom_range(0, 1)));
         end else begin
            // cut the packet short, then send a line error, a stop or an arm
            queue_packet(adr, len, $urandom_range(0, ndata - 1), 1'b0,
                         1'($urandom_range(0, 1)));
            sel = $urandom_range(0, 2);
            fe  = 1'($urandom_range(0, 1));
            if (sel == 0)
               queue_req(OP_CHAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         fe, !fe || ($urandom_range(0, 1) != 0),
                         8'($urandom_range(0, 255)));
            else if (sel == 1)
               queue_req(OP_STOP, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0,
                         8'($urandom_range(0, 255)));
            else
               queue_req(OP_ARM, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0,
                         8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Wait until every queued request is accepted and every response is back.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || predicted_rsps.size() != 0);
   endtask

   // Write the node address while the receiver is idle.
   task automatic write_node_address(logic [7:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      node_addr = value;
      addr_settings++;
   endtask

   // Stimulus: reset, directed requests, then random traffic in phases, each
   // under its own node address.
   initial begin : stimulus
      logic [7:0] phase_addrs[6];
      int unsigned phase_end;
      int          ph;
      phase_addrs[0] = 8'hFF;
      phase_addrs[1] = 8'($urandom_range(1, 254));
      phase_addrs[2] = 8'h01;
      phase_addrs[3] = 8'($urandom_range(0, 255));
      phase_addrs[4] = 8'h00;
      phase_addrs[5] = 8'h80;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_node_address(8'h00);

      // characters while disarmed, the unused opcode, a stop when idle
      queue_req(OP_CHAR, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF);
      queue_req(OP_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF);
      queue_req(OP_STOP, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
      // arm, then a refused second arm
      queue_req(OP_ARM, 8'h00, 1'b0, 1'b0, 1'b0, 8'd4);
      queue_req(OP_ARM, 8'h00, 1'b0, 1'b0, 1'b0, 8'd255);
      // a data character and a foreign address are dropped
      queue_req(OP_CHAR, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
      queue_req(OP_CHAR, 8'hAA, 1'b1, 1'b0, 1'b0, 8'h00);
      // full packet with acknowledge and good checksum
      queue_packet(8'h00, 4, 3, 1'b1, 1'b1);
      // lengths zero and one complete on the first data character
      queue_req(OP_ARM, 8'hFF, 1'b1, 1'b1, 1'b1, 8'd0);
      queue_packet(8'h00, 0, 1, 1'b1, 1'b0);
      queue_req(OP_ARM, 8'h00, 1'b0, 1'b0, 1'b0, 8'd1);
      queue_packet(8'h00, 1, 1, 1'b0, 1'b1);
      // framing error in the middle of a packet
      queue_req(OP_ARM, 8'h00, 1'b0, 1'b0, 1'b0, 8'd255);
      queue_packet(8'h00, 255, 1, 1'b0, 1'b0);
      queue_req(OP_CHAR, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00);
      // overrun while still hunting for the address
      queue_req(OP_ARM, 8'h00, 1'b0, 1'b0, 1'b0, 8'd6);
      queue_req(OP_CHAR, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00);
      // stop in the middle of a packet
      queue_req(OP_ARM, 8'h00, 1'b0, 1'b0, 1'b0, 8'd8);
      queue_packet(8'h00, 8, 1, 1'b0, 1'b0);
      queue_req(OP_STOP, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF);

      for (ph = 0; ph < 6; ph++) begin
         wait_idle();
         write_node_address(phase_addrs[ph]);
         phase_end = queued_count + 105;
         while (queued_count < phase_end)
            queue_traffic(phase_addrs[ph]);
      end

      // drain, then give a late extra response a chance to show up
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Ran %0d requests under %0d node address settings, %0d responses checked.",
               accepted_count, addr_settings, checked_count);
      $display("Seen: %0d packets completed (%0d checksum ok), %0d overflows, %0d line errors.",
               n_complete, n_sum_good, n_overflow, n_line_err);
      if (mismatch_count == 0)
         $display("[addressed_9bit_packet_receiver_core] OK");
      else
         $display("[addressed_9bit_packet_receiver_core] ERROR");
      $finish;
   end

   // Watchdog: end a hung run.
   initial begin : watchdog
      #5_000_000;
      $display("timed out with %0d responses still expected", predicted_rsps.size());
      $display("[addressed_9bit_packet_receiver_core] ERROR");
      $finish;
   end

endmodule

[addressed_9bit_packet_receiver_core.f]
rtl/core/a9pr_pkg.sv
rtl/core/addressed_9bit_packet_receiver_core.sv
tb/sv/addressed_9bit_packet_receiver_core_test.sv
